[rtl/core/phb_pkg.sv]
// ----------------------------------------------------------------------------
// phb_pkg
// shared widths, constants and codes of the peak-hold bar graph
// ----------------------------------------------------------------------------
package phb_pkg;

  // sizing
  localparam int unsigned HISTORY_DEPTH = 32;
  localparam int unsigned BAR_ROWS      = 16;
  localparam int unsigned RESULT_LIMIT  = 32;
  localparam int unsigned RUN_LEN       = (HISTORY_DEPTH < RESULT_LIMIT) ?
                                          HISTORY_DEPTH : RESULT_LIMIT;

  localparam int unsigned HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned RUN_W   = $clog2(RUN_LEN);
  localparam int unsigned ROW_W   = $clog2(BAR_ROWS);
  localparam int unsigned BIT_W   = (ROW_W > 1) ? $clog2(ROW_W) : 1;
  localparam int unsigned PIXV_W  = $clog2(BAR_ROWS + 1);

  // field widths
  localparam int unsigned SAMPLE_W  = 20;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned AGE_W     = 5;
  localparam int unsigned PIX_W     = 5;
  localparam int unsigned WHOLE_W   = 16;
  localparam int unsigned TENTHS_W  = 4;

  // datapath widths
  localparam int unsigned DIV_W = 20;                   // 10 * full scale
  localparam int unsigned NUM_W = SAMPLE_W + ROW_W + 1; // sample * rows
  localparam int unsigned QUO_W = 17;                   // 20 bit value / 10

  // divide by ten through a reciprocal, exact for 20 bit values
  localparam int unsigned RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP = 20'd838861;
  localparam int unsigned RECIP_SHIFT = 23;

  localparam int unsigned TEN = 10;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] FULL_SCALE_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] GRAPH_PERIOD_RST = 16'd1000;
  localparam logic [CFG_W-1:0] VALUE_HOLD_RST   = 16'd3000;

  localparam logic [CFG_W-1:0] TIMER_MAX = '1;

  // item kinds
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SCALE   = 2'd0,
    CFG_GRAPH_PERIOD = 2'd1,
    CFG_VALUE_HOLD   = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } phb_state_e;

endpackage

[rtl/core/phb_if.sv]
// ----------------------------------------------------------------------------
// phb_if
// valid/ready channels of the peak-hold bar graph
// ----------------------------------------------------------------------------

// input items: power samples and ticks
interface phb_in_if import phb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output mode, output sample_value, input ready);
  modport sink   (input valid, input mode, input sample_value, output ready);
endinterface

// result items: one bar per history slot
interface phb_out_if import phb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [AGE_W-1:0]    age_index;
  logic [PIX_W-1:0]    bar_pixels;
  logic [WHOLE_W-1:0]  held_whole;
  logic [TENTHS_W-1:0] held_tenths;
  logic                last_of_run;

  modport source (output valid, output age_index, output bar_pixels, output held_whole,
                  output held_tenths, output last_of_run, input ready);
  modport sink   (input valid, input age_index, input bar_pixels, input held_whole,
                  input held_tenths, input last_of_run, output ready);
endinterface

// configuration writes
interface phb_cfg_if import phb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/phb_ram.sv]
// ----------------------------------------------------------------------------
// phb_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module phb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/core/peak_hold_bar_graph.sv]
// ----------------------------------------------------------------------------
// peak_hold_bar_graph
// peak tracking with held display value and ring history of peaks for bar heights
// ----------------------------------------------------------------------------
// usage
//   sample_i carries items: a power sample in tenths of a watt, or a tick
//   cfg_i writes full scale, graph period and hold time; the user writes them
//   only while the block idles, which the block itself does not enforce
//   result_o gives one bar per history slot, newest first, after a tick that
//   ends a graph period; last_of_run marks the final column of a redraw
// redraw sequence
//   a sample, or a tick that ends no period, leaves the block idle and ready
//   for the next item; a redraw walks the history of 32 columns through the
//   ram, one column at a time: ram read, load, up to 4 restoring divide steps
//   (none for an empty or a full bar), then the output state
//   sample_i is not ready while a redraw is running
// reset
//   control registers clear at once; every history slot reads as empty
//   through its valid bit until written, so no clearing pass is needed
// stalls
//   a column stays on result_o until taken; the walk simply waits
// ----------------------------------------------------------------------------
module peak_hold_bar_graph import phb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  phb_cfg_if.sink   cfg_i,
  phb_in_if.sink    sample_i,
  phb_out_if.source result_o
);

  // configuration
  logic [CFG_W-1:0] full_scale_q, period_q, hold_ticks_q;

  // tracking state
  logic [SAMPLE_W-1:0]      graph_peak_q, disp_peak_q;
  logic [CFG_W-1:0]         graph_timer_q, hold_timer_q;
  logic [HIST_AW-1:0]       wr_slot_q;
  logic [HISTORY_DEPTH-1:0] valid_q;

  // redraw datapath
  phb_state_e          state_q, state_d;
  logic [HIST_AW-1:0]  rd_idx_q;
  logic [RUN_W-1:0]    age_q;
  logic [DIV_W-1:0]    div_q;
  logic [SAMPLE_W-1:0] disp_snap_q;
  logic [WHOLE_W-1:0]  whole_q;
  logic [TENTHS_W-1:0] tenths_q;
  logic [NUM_W-1:0]    rem_q;
  logic [ROW_W-1:0]    quo_q;
  logic [BIT_W-1:0]    bit_q;
  logic [PIXV_W-1:0]   pix_q;

  // ---------------------------------------------------------------------------
  // configuration port, always ready; unknown indexes are dropped
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FULL_SCALE_RST;
      period_q     <= GRAPH_PERIOD_RST;
      hold_ticks_q <= VALUE_HOLD_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_FULL_SCALE:   full_scale_q <= cfg_i.data;
        CFG_GRAPH_PERIOD: period_q     <= cfg_i.data;
        CFG_VALUE_HOLD:   hold_ticks_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // item decode and tick arithmetic
  // ---------------------------------------------------------------------------
  logic                in_acc, samp_acc, tick_acc;
  logic [CFG_W-1:0]    hold_inc, graph_inc;
  logic                hold_expired, redraw;
  logic [SAMPLE_W-1:0] disp_after;
  logic [CFG_W-1:0]    fs_eff;
  logic [HIST_AW-1:0]  wr_slot_nxt, rd_idx_nxt;

  assign in_acc   = sample_i.valid && sample_i.ready;
  assign samp_acc = in_acc && (sample_i.mode == MODE_SAMPLE);
  assign tick_acc = in_acc && (sample_i.mode == MODE_TICK);

  // timers saturate instead of wrapping
  assign hold_inc  = (hold_timer_q == TIMER_MAX) ? hold_timer_q : hold_timer_q + 1'b1;
  assign graph_inc = (graph_timer_q == TIMER_MAX) ? graph_timer_q : graph_timer_q + 1'b1;

  assign hold_expired = (hold_inc >= hold_ticks_q);
  assign redraw       = (graph_inc >= period_q);
  assign disp_after   = hold_expired ? '0 : disp_peak_q;

  // a zero full scale acts as one watt
  assign fs_eff = (full_scale_q == '0) ? CFG_W'(1) : full_scale_q;

  assign wr_slot_nxt = (wr_slot_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wr_slot_q + 1'b1;
  assign rd_idx_nxt  = (rd_idx_q == '0) ? HIST_AW'(HISTORY_DEPTH - 1) : rd_idx_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      graph_peak_q  <= '0;
      disp_peak_q   <= '0;
      graph_timer_q <= '0;
      hold_timer_q  <= '0;
      wr_slot_q     <= '0;
      valid_q       <= '0;
    end else if (samp_acc) begin
      if (sample_i.sample_value > graph_peak_q) begin
        graph_peak_q <= sample_i.sample_value;
      end
      // an equal sample does not restart the hold
      if (sample_i.sample_value > disp_peak_q) begin
        disp_peak_q  <= sample_i.sample_value;
        hold_timer_q <= '0;
      end
    end else if (tick_acc) begin
      hold_timer_q <= hold_inc;
      disp_peak_q  <= disp_after;
      if (redraw) begin
        graph_peak_q       <= '0;
        graph_timer_q      <= '0;
        wr_slot_q          <= wr_slot_nxt;
        valid_q[wr_slot_q] <= 1'b1;
      end else begin
        graph_timer_q <= graph_inc;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // history ram, written with the graph peak at the end of each period
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] ram_rdata, slot_data;

  phb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (tick_acc && redraw),
    .waddr_i (wr_slot_q),
    .wdata_i (graph_peak_q),
    .re_i    (state_q == ST_READ),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // slots never written read as empty
  assign slot_data = valid_q[rd_idx_q] ? ram_rdata : '0;

  // ---------------------------------------------------------------------------
  // held value split into whole watts and tenths (reciprocal multiply)
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W+RECIP_W-1:0] held_prod;
  logic [QUO_W-1:0]            held_quo;
  logic [SAMPLE_W-1:0]         held_rem;

  assign held_prod = (SAMPLE_W+RECIP_W)'(disp_snap_q) * (SAMPLE_W+RECIP_W)'(RECIP);
  assign held_quo  = held_prod[RECIP_SHIFT +: QUO_W];
  assign held_rem  = disp_snap_q - (SAMPLE_W'(held_quo) * SAMPLE_W'(TEN));

  // ---------------------------------------------------------------------------
  // bar: floor(rows*sample/(10*full scale))+1, 0 if empty, at most rows; one quotient bit a step
  // ---------------------------------------------------------------------------
  logic [NUM_W-1:0] div_shift;
  logic             rem_ge;
  logic [ROW_W-1:0] quo_set;
  logic             last_col;

  assign div_shift = NUM_W'(div_q) << bit_q;
  assign rem_ge    = (rem_q >= div_shift);
  assign quo_set   = quo_q | (ROW_W'(1) << bit_q);
  assign last_col  = (age_q == RUN_W'(RUN_LEN - 1));

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (tick_acc && redraw) begin
          rd_idx_q    <= wr_slot_q;
          age_q       <= '0;
          div_q       <= DIV_W'(fs_eff) * DIV_W'(TEN);
          disp_snap_q <= disp_after;
        end
      end
      ST_READ: begin
        whole_q  <= (held_quo > QUO_W'(TIMER_MAX)) ? TIMER_MAX : held_quo[WHOLE_W-1:0];
        tenths_q <= held_rem[TENTHS_W-1:0];
      end
      ST_LOAD: begin
        rem_q <= NUM_W'(slot_data) * NUM_W'(BAR_ROWS);
        quo_q <= '0;
        bit_q <= BIT_W'(ROW_W - 1);
        if (slot_data == '0) begin
          pix_q <= '0;
        end else if (DIV_W'(slot_data) >= div_q) begin
          pix_q <= PIXV_W'(BAR_ROWS);
        end
      end
      ST_DIV: begin
        if (rem_ge) begin
          rem_q <= rem_q - div_shift;
          quo_q <= quo_set;
        end
        if (bit_q == '0) begin
          pix_q <= PIXV_W'(rem_ge ? quo_set : quo_q) + 1'b1;
        end else begin
          bit_q <= bit_q - 1'b1;
        end
      end
      ST_OUT: begin
        if (result_o.ready && !last_col) begin
          age_q    <= age_q + 1'b1;
          rd_idx_q <= rd_idx_nxt;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // redraw sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    sample_i.ready = 1'b0;
    result_o.valid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        sample_i.ready = 1'b1;
        if (tick_acc && redraw) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: begin
        // empty and full bars skip the divide
        if ((slot_data == '0) || (DIV_W'(slot_data) >= div_q)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (bit_q == '0) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        result_o.valid = 1'b1;
        if (result_o.ready) begin
          state_d = last_col ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign result_o.age_index   = AGE_W'(age_q);
  assign result_o.bar_pixels  = PIX_W'(pix_q);
  assign result_o.held_whole  = whole_q;
  assign result_o.held_tenths = tenths_q;
  assign result_o.last_of_run = last_col;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // no new item is taken while a column is being shown
  a_no_input_during_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sample_i.ready && result_o.valid))
    else $error("input ready while a column is pending");

  // the last column handed over returns the block to accepting items
  a_run_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && result_o.last_of_run) |=> sample_i.ready)
    else $error("block not idle after the last column");

  // a redraw starts at the newest slot with age zero
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_acc && redraw) |=> ((age_q == '0) && (rd_idx_q == $past(wr_slot_q))))
    else $error("redraw did not start at the newest slot");

  // bar height never exceeds the rows
  a_pix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (pix_q <= PIXV_W'(BAR_ROWS)))
    else $error("bar height above row count");

endmodule
